>>> hw/rtl/bta_pkg.sv
`timescale 1ns / 1ps

package bta_pkg;

    localparam int VALUE_W     = 32;
    localparam int CONV_STEPS  = 4;
    localparam int CONV_CYCLES = VALUE_W / CONV_STEPS;
    localparam int CNT_W       = $clog2(CONV_CYCLES);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_signed;
        logic [3:0]         min_digits;
        logic [3:0]         frac_digits;
    } t_in_req;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_req;

    typedef struct packed {
        logic       negative;
        logic       is_signed;
        logic [3:0] min_digits;
        logic [3:0] frac_digits;
    } t_fmt;

    typedef enum logic [2:0] {
        EMIT_IDLE,
        EMIT_SIGN,
        EMIT_DOT,
        EMIT_DIGIT,
        EMIT_ZERO
    } t_emit_state;

endpackage

>>> hw/rtl/bta_digit_cell.sv
`timescale 1ns / 1ps

module bta_digit_cell (
    input  logic                            i_clk,
    input  logic                            i_clear,
    input  logic                            i_step,
    input  logic [bta_pkg::CONV_STEPS-1:0]  i_cin,
    output logic [bta_pkg::CONV_STEPS-1:0]  o_cout,
    output logic [3:0]                      o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;

    always_comb begin
        logic [3:0] v;
        v = r_digit;
        for (int s = 0; s < bta_pkg::CONV_STEPS; s++) begin
            if (v >= 4'd5) begin
                v = v + 4'd3;
            end
            o_cout[s] = v[3];
            v = {v[2:0], i_cin[s]};
        end
        n_digit = v;
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_digit <= 4'd0;
        end else if (i_step) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

>>> hw/rtl/bta_emit.sv
`timescale 1ns / 1ps

module bta_emit #(
    parameter int DIGITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ld_valid,
    output logic              o_ld_ready,
    input  bta_pkg::t_fmt     i_fmt,
    input  logic [3:0]        i_digits [DIGITS],
    output logic              o_valid,
    input  logic              i_ready,
    output bta_pkg::t_out_req o_data
);

    localparam int POS_W = $clog2(DIGITS + 1);
    localparam int CW    = (POS_W > 4) ? POS_W : 4;

    bta_pkg::t_emit_state r_state, n_state;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [3:0]           r_dig [DIGITS];
    logic                 r_neg;
    logic [3:0]           r_frac;

    logic [POS_W-1:0]     w_start;
    logic [3:0]           w_cur;
    logic                 w_take;
    logic                 w_done;
    logic                 w_load;

    always_comb begin
        logic [POS_W-1:0] hi;
        logic [POS_W-1:0] md;
        logic [POS_W-1:0] fd;
        hi = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (i_digits[k] != 4'd0) begin
                hi = POS_W'(k + 1);
            end
        end
        md = (CW'(i_fmt.min_digits) > CW'(DIGITS)) ? POS_W'(DIGITS)
                                                    : POS_W'(i_fmt.min_digits);
        fd = (CW'(i_fmt.frac_digits) > CW'(DIGITS)) ? POS_W'(DIGITS)
                                                     : POS_W'(i_fmt.frac_digits);
        w_start = hi;
        if (md > w_start) begin
            w_start = md;
        end
        if (fd > w_start) begin
            w_start = fd;
        end
    end

    always_comb begin
        w_cur = 4'd0;
        for (int k = 0; k < DIGITS; k++) begin
            if (r_pos == POS_W'(k + 1)) begin
                w_cur = r_dig[k];
            end
        end
    end

    always_comb begin
        o_valid          = (r_state != bta_pkg::EMIT_IDLE);
        o_data.character = bta_pkg::CHAR_ZERO;
        o_data.last      = 1'b0;
        unique case (r_state)
            bta_pkg::EMIT_IDLE: begin
                o_data.character = bta_pkg::CHAR_ZERO;
                o_data.last      = 1'b0;
            end
            bta_pkg::EMIT_SIGN: begin
                o_data.character = r_neg ? bta_pkg::CHAR_MINUS : bta_pkg::CHAR_PLUS;
                o_data.last      = (r_pos == '0);
            end
            bta_pkg::EMIT_DOT: begin
                o_data.character = bta_pkg::CHAR_DOT;
                o_data.last      = 1'b0;
            end
            bta_pkg::EMIT_DIGIT: begin
                o_data.character = bta_pkg::CHAR_ZERO + {4'd0, w_cur};
                o_data.last      = (r_pos == POS_W'(1));
            end
            bta_pkg::EMIT_ZERO: begin
                o_data.character = bta_pkg::CHAR_ZERO;
                o_data.last      = 1'b1;
            end
            default: begin
                o_data.character = bta_pkg::CHAR_ZERO;
                o_data.last      = 1'b0;
            end
        endcase
        w_take     = o_valid && i_ready;
        w_done     = w_take && o_data.last;
        o_ld_ready = (r_state == bta_pkg::EMIT_IDLE) || w_done;
        w_load     = i_ld_valid && o_ld_ready;
    end

    always_comb begin
        logic [POS_W-1:0] pos_dn;
        pos_dn  = r_pos - POS_W'(1);
        n_state = r_state;
        n_pos   = r_pos;
        priority if (w_load) begin
            n_pos = w_start;
            priority if (i_fmt.is_signed) begin
                n_state = bta_pkg::EMIT_SIGN;
            end else if (w_start == '0) begin
                n_state = bta_pkg::EMIT_ZERO;
            end else if (CW'(w_start) == CW'(i_fmt.frac_digits)) begin
                n_state = bta_pkg::EMIT_DOT;
            end else begin
                n_state = bta_pkg::EMIT_DIGIT;
            end
        end else if (w_done) begin
            n_state = bta_pkg::EMIT_IDLE;
        end else if (w_take) begin
            unique case (r_state)
                bta_pkg::EMIT_SIGN: begin
                    n_state = (CW'(r_pos) == CW'(r_frac)) ? bta_pkg::EMIT_DOT
                                                          : bta_pkg::EMIT_DIGIT;
                end
                bta_pkg::EMIT_DOT: begin
                    n_state = bta_pkg::EMIT_DIGIT;
                end
                bta_pkg::EMIT_DIGIT: begin
                    n_pos   = pos_dn;
                    n_state = (CW'(pos_dn) == CW'(r_frac)) ? bta_pkg::EMIT_DOT
                                                           : bta_pkg::EMIT_DIGIT;
                end
                bta_pkg::EMIT_IDLE,
                bta_pkg::EMIT_ZERO: begin
                    n_state = r_state;
                end
                default: begin
                    n_state = bta_pkg::EMIT_IDLE;
                end
            endcase
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bta_pkg::EMIT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (w_load) begin
            r_dig  <= i_digits;
            r_neg  <= i_fmt.negative;
            r_frac <= i_fmt.frac_digits;
        end
    end

endmodule

>>> hw/rtl/binary_to_ascii_decimal_unit.sv
`timescale 1ns / 1ps

// Channel  Valid    Ready    Payload  Moves
// in       i_valid  o_ready  i_data   one number request (value, mode, widths)
// out      o_valid  i_ready  o_data   one ASCII character, last on the final one
//
// A request is converted by a row of BCD digit cells, 4 bits per cycle.
// Characters leave one per cycle while i_ready is high, as the next request converts.
// Each request yields 1 to 12 characters.
// Synchronous reset clears control only; there is no clearing pass.
// A stalled output holds its character; a finished conversion waits, with o_ready low.

module binary_to_ascii_decimal_unit #(
    parameter int DIGITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bta_pkg::t_in_req  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output bta_pkg::t_out_req o_data
);

    logic                         r_busy, n_busy;
    logic                         r_full, n_full;
    logic [bta_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [bta_pkg::VALUE_W-1:0]  r_mag;
    bta_pkg::t_fmt                r_fmt;

    logic                         w_accept;
    logic                         w_ld_ready;
    logic                         w_hand;
    logic                         w_neg;
    logic [bta_pkg::VALUE_W-1:0]  w_mag;

    logic [bta_pkg::CONV_STEPS-1:0] w_link  [DIGITS];
    logic [3:0]                     w_digit [DIGITS];

    assign w_hand   = r_full && w_ld_ready;
    assign o_ready  = !r_busy && (!r_full || w_hand);
    assign w_accept = i_valid && o_ready;

    assign w_neg = i_data.is_signed && i_data.value[bta_pkg::VALUE_W-1];
    assign w_mag = w_neg ? (~i_data.value + bta_pkg::VALUE_W'(1)) : i_data.value;

    always_comb begin
        n_busy = r_busy;
        n_full = r_full;
        n_cnt  = r_cnt;
        if (w_hand) begin
            n_full = 1'b0;
        end
        if (w_accept) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + bta_pkg::CNT_W'(1);
            if (r_cnt == bta_pkg::CNT_W'(bta_pkg::CONV_CYCLES - 1)) begin
                n_busy = 1'b0;
                n_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_full <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_full <= n_full;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag           <= w_mag;
            r_fmt.negative    <= w_neg;
            r_fmt.is_signed   <= i_data.is_signed;
            r_fmt.min_digits  <= i_data.min_digits;
            r_fmt.frac_digits <= i_data.frac_digits;
        end else if (r_busy) begin
            r_mag <= r_mag << bta_pkg::CONV_STEPS;
        end
    end

    for (genvar s = 0; s < bta_pkg::CONV_STEPS; s++) begin : g_feed
        assign w_link[0][s] = r_mag[bta_pkg::VALUE_W-1-s];
    end

    for (genvar k = 0; k < DIGITS; k++) begin : g_cell
        if (k < DIGITS - 1) begin : g_mid
            bta_digit_cell u_cell (
                .i_clk   (i_clk),
                .i_clear (w_accept),
                .i_step  (r_busy),
                .i_cin   (w_link[k]),
                .o_cout  (w_link[k+1]),
                .o_digit (w_digit[k])
            );
        end else begin : g_top
            bta_digit_cell u_cell (
                .i_clk   (i_clk),
                .i_clear (w_accept),
                .i_step  (r_busy),
                .i_cin   (w_link[k]),
                .o_cout  (),
                .o_digit (w_digit[k])
            );
        end
    end

    bta_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld_valid (r_full),
        .o_ld_ready (w_ld_ready),
        .i_fmt      (r_fmt),
        .i_digits   (w_digit),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

>>> bench/binary_to_ascii_decimal_unit_tb.sv
`timescale 1ns / 1ps

class char_scoreboard #(int DIGITS = 10);
    bta_pkg::t_out_req due_chars[$];
    int                errors;
    int                checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    function void push_char(logic [7:0] ch);
        bta_pkg::t_out_req c;
        c.character = ch;
        c.last      = 1'b0;
        due_chars.push_back(c);
    endfunction

    function void format_decimal(bta_pkg::t_in_req r);
        logic [63:0] mag;
        logic [63:0] scale;
        logic [31:0] neg;
        int          dig;
        int          pos;
        int          first;
        bit          started;
        first   = due_chars.size();
        started = 1'b0;
        neg     = ~r.value + 32'd1;
        if (r.is_signed && r.value[31]) begin
            push_char(bta_pkg::CHAR_MINUS);
            mag = {32'd0, neg};
        end else begin
            if (r.is_signed) begin
                push_char(bta_pkg::CHAR_PLUS);
            end
            mag = {32'd0, r.value};
        end
        scale = 64'd1;
        for (pos = 1; pos < DIGITS; pos++) begin
            scale = scale * 64'd10;
        end
        if (DIGITS < 10) begin
            mag = mag % (scale * 64'd10);
        end
        for (pos = DIGITS; pos >= 1; pos--) begin
            dig = (mag >= scale) ? int'(mag / scale) : 0;
            mag = mag - 64'(dig) * scale;
            if (pos == int'(r.frac_digits)) begin
                push_char(bta_pkg::CHAR_DOT);
            end
            if (started || pos <= int'(r.min_digits) || dig > 0
                    || pos <= int'(r.frac_digits)) begin
                push_char(bta_pkg::CHAR_ZERO + 8'(dig));
                started = 1'b1;
            end
            if (scale > 64'd1) begin
                scale = scale / 64'd10;
            end
        end
        if (due_chars.size() == first) begin
            push_char(bta_pkg::CHAR_ZERO);
        end
        due_chars[due_chars.size() - 1].last = 1'b1;
    endfunction

    function void note_request(bta_pkg::t_in_req r);
        format_decimal(r);
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_char(bta_pkg::t_out_req got);
        bta_pkg::t_out_req want;
        if (due_chars.size() == 0) begin
            report($sformatf("character 0x%02h (last %0b) with no request pending",
                             got.character, got.last));
            return;
        end
        want = due_chars.pop_front();
        checked++;
        if (got.character !== want.character) begin
            report($sformatf("character 0x%02h, wanted 0x%02h",
                             got.character, want.character));
        end
        if (got.last !== want.last) begin
            report($sformatf("last %0b on character 0x%02h, wanted %0b",
                             got.last, got.character, want.last));
        end
    endtask
endclass

module binary_to_ascii_decimal_unit_tb;

    localparam int DIGITS         = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 300;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 30;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    bta_pkg::t_in_req  i_data;
    logic              o_valid;
    logic              i_ready;
    bta_pkg::t_out_req o_data;

    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int quiet_cycles;
    int n_requests;
    int n_signed;
    int n_negative;

    char_scoreboard #(DIGITS) sb;

    binary_to_ascii_decimal_unit #(
        .DIGITS(DIGITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_valid && o_ready) begin
                sb.note_request(i_data);
                n_requests++;
                if (i_data.is_signed) begin
                    n_signed++;
                end
                if (i_data.is_signed && i_data.value[31]) begin
                    n_negative++;
                end
                quiet_cycles = 0;
            end
            if (o_valid && i_ready) begin
                sb.check_char(o_data);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: %0d cycles without a handshake", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    function automatic bta_pkg::t_in_req make_request(logic [31:0] value, logic sgn,
                                                      logic [3:0] min_d,
                                                      logic [3:0] frac_d);
        bta_pkg::t_in_req r;
        r.value       = value;
        r.is_signed   = sgn;
        r.min_digits  = min_d;
        r.frac_digits = frac_d;
        return r;
    endfunction

    function automatic logic [31:0] rand_value();
        logic [31:0] p;
        int          k;
        p = 32'd1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($urandom_range(0, 99));
            2: begin
                k = $urandom_range(0, 9);
                repeat (k) p = p * 32'd10;
                return p - 32'd1 + 32'($urandom_range(0, 2));
            end
            3: return 32'd0 - 32'($urandom_range(1, 1000));
            4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($urandom_range(0, 999999));
        endcase
    endfunction

    function automatic logic [3:0] rand_width();
        if ($urandom_range(0, 7) == 0) begin
            return 4'($urandom_range(11, 15));
        end
        return 4'($urandom_range(0, 10));
    endfunction

    task automatic send_request(input bta_pkg::t_in_req r);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_chars.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(make_request(32'd0, 1'b0, 4'd0, 4'd0));
        send_request(make_request(32'd0, 1'b1, 4'd0, 4'd0));
        send_request(make_request(32'h8000_0000, 1'b1, 4'd0, 4'd0));
        send_request(make_request(32'hFFFF_FFFF, 1'b0, 4'd0, 4'd0));
        send_request(make_request(32'hFFFF_FFFF, 1'b1, 4'd0, 4'd0));
        send_request(make_request(32'h7FFF_FFFF, 1'b1, 4'd0, 4'd0));
        send_request(make_request(32'd5, 1'b0, 4'd15, 4'd0));
        send_request(make_request(32'd5, 1'b0, 4'd11, 4'd0));
        send_request(make_request(32'd12345, 1'b0, 4'd0, 4'd15));
        send_request(make_request(32'd12345, 1'b0, 4'd0, 4'd10));
        send_request(make_request(32'd12345, 1'b0, 4'd0, 4'd2));
        send_request(make_request(32'd7, 1'b0, 4'd0, 4'd3));
        send_request(make_request(32'd0, 1'b0, 4'd0, 4'd1));
        send_request(make_request(32'd0, 1'b0, 4'd10, 4'd0));
        send_request(make_request(32'hFFFF_FFFF, 1'b1, 4'd15, 4'd10));
        send_request(make_request(32'h8000_0000, 1'b1, 4'd10, 4'd10));
        send_request(make_request(32'd1000000000, 1'b0, 4'd0, 4'd0));
        send_request(make_request(32'd999999999, 1'b1, 4'd3, 4'd4));
        send_request(make_request(32'd42, 1'b0, 4'd5, 4'd0));
        send_request(make_request(32'd0, 1'b1, 4'd1, 4'd0));
        send_request(make_request(32'd0, 1'b1, 4'd0, 4'd12));
        send_request(make_request(32'hA5A5_A5A5, 1'b0, 4'd7, 4'd9));
        send_request(make_request(32'h5A5A_5A5A, 1'b1, 4'd8, 4'd6));
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 80) begin
                hold_req = 1'b1;
            end
            if (n == 180) begin
                wait_drained();
            end
            if (n == RANDOM_ITEMS - 50) begin
                idle_on = 1'b0;
            end
            send_request(make_request(rand_value(), 1'($urandom_range(0, 1)),
                                      rand_width(), rand_width()));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers (%0d signed, %0d negative) into %0d checked characters.",
                 n_requests, n_signed, n_negative, sb.checked);
        $display("Covered random idling, a %0d-cycle output stall and full drains.", LONG_HOLD);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/bta_pkg.sv
hw/rtl/bta_digit_cell.sv
hw/rtl/bta_emit.sv
hw/rtl/binary_to_ascii_decimal_unit.sv
bench/binary_to_ascii_decimal_unit_tb.sv
